// ===== rtl/atql_pkg.sv =====
// Shared types, widths and codes for the alarm table qualifier and latch.
`timescale 1ns / 1ps

package atql_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 64;

    localparam int INDEX_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int LED_W    = 2;
    localparam int COUNT_W  = 7;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_EVAL = 1'b1;

    localparam logic [LED_W-1:0] LED_NONE       = 2'd0;
    localparam logic [LED_W-1:0] LED_FAULT_ONLY = 2'd2;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_STEADY = 2'd2;
    localparam logic [1:0] MODE_DOUBLE = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    typedef struct packed {
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] limit;
        logic [LED_W-1:0]  led;
        logic              storable;
        logic [BYTE_W-1:0] wait_cnt;
        logic              active;
        logic              latched;
    } row_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

// ===== rtl/atql_in_if.sv =====
// Input channel carrying load and evaluate beats.
`timescale 1ns / 1ps

interface atql_in_if;
    import atql_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [INDEX_W-1:0]   entry_index;
    logic [BYTE_W-1:0]    source_status;
    logic [BYTE_W-1:0]    entry_mask;
    logic [BYTE_W-1:0]    wait_limit;
    logic [LED_W-1:0]     led_bits;
    logic                 storable;
    logic                 acknowledge;
    logic                 last_of_scan;

    modport source (
        output valid, action, entry_index, source_status, entry_mask, wait_limit,
               led_bits, storable, acknowledge, last_of_scan,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, source_status, entry_mask, wait_limit,
               led_bits, storable, acknowledge, last_of_scan,
        output ready
    );
endinterface

// ===== rtl/atql_out_if.sv =====
// Output channel carrying one result beat per input beat.
`timescale 1ns / 1ps

interface atql_out_if;
    import atql_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 entry_active;
    logic                 entry_latched;
    logic                 summary_valid;
    logic [1:0]           led_mode;
    logic                 alarm_relay;
    logic                 any_alarm;
    logic                 unacked_present;
    logic [COUNT_W-1:0]   active_count;

    modport source (
        output valid, entry_active, entry_latched, summary_valid, led_mode,
               alarm_relay, any_alarm, unacked_present, active_count,
        input  ready
    );

    modport sink (
        input  valid, entry_active, entry_latched, summary_valid, led_mode,
               alarm_relay, any_alarm, unacked_present, active_count,
        output ready
    );
endinterface

// ===== rtl/atql_ctrl.sv =====
// Controller state machine sequencing table read, write-back and result hand-off.
`timescale 1ns / 1ps

module atql_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output atql_pkg::cmd_t  cmd
);
    import atql_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_free    = !out_valid_reg || out_ready;
    assign cmd.capture = (state_reg == ST_IDLE) && in_valid;
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== rtl/atql_datapath.sv =====
// Datapath with the entry table memory, qualification logic, scan summary and result register.
`timescale 1ns / 1ps

module atql_datapath #(
    parameter int TABLE_DEPTH = atql_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  atql_pkg::cmd_t                cmd,
    input  logic                          in_action,
    input  logic [atql_pkg::INDEX_W-1:0]  in_entry_index,
    input  logic [atql_pkg::BYTE_W-1:0]   in_source_status,
    input  logic [atql_pkg::BYTE_W-1:0]   in_entry_mask,
    input  logic [atql_pkg::BYTE_W-1:0]   in_wait_limit,
    input  logic [atql_pkg::LED_W-1:0]    in_led_bits,
    input  logic                          in_storable,
    input  logic                          in_acknowledge,
    input  logic                          in_last_of_scan,
    output logic                          res_entry_active,
    output logic                          res_entry_latched,
    output logic                          res_summary_valid,
    output logic [1:0]                    res_led_mode,
    output logic                          res_alarm_relay,
    output logic                          res_any_alarm,
    output logic                          res_unacked_present,
    output logic [atql_pkg::COUNT_W-1:0]  res_active_count
);
    import atql_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    row_t                 mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] row_valid_reg;

    logic [AW-1:0]        rd_addr;
    logic                 rd_in_range;
    row_t                 rd_row_reg;
    logic                 rd_valid_reg;

    logic                 latching_mode_reg;

    logic                 cap_action_reg;
    logic [AW-1:0]        cap_addr_reg;
    logic                 cap_in_range_reg;
    logic [BYTE_W-1:0]    cap_status_reg;
    logic [BYTE_W-1:0]    cap_mask_reg;
    logic [BYTE_W-1:0]    cap_limit_reg;
    logic [LED_W-1:0]     cap_led_reg;
    logic                 cap_storable_reg;
    logic                 cap_ack_reg;
    logic                 cap_last_reg;

    logic [LED_W-1:0]     scan_led_reg;
    logic [LED_W-1:0]     scan_led_next;
    logic                 scan_latch_reg;
    logic                 scan_latch_next;
    logic [COUNT_W-1:0]   scan_count_reg;
    logic [COUNT_W-1:0]   scan_count_next;
    logic [1:0]           held_mode_reg;
    logic [1:0]           held_mode_next;
    logic                 held_unacked_reg;
    logic                 held_unacked_next;

    row_t                 cur_row;
    row_t                 row_next;
    logic                 row_we;
    logic                 disabled;
    logic                 hit;
    logic [BYTE_W:0]      cnt_inc;
    logic                 eval_ok;
    logic [LED_W-1:0]     led_acc;
    logic                 latch_acc;
    logic [COUNT_W-1:0]   count_acc;
    logic                 act;
    logic                 lat;
    logic                 summary;
    logic [1:0]           mode;
    logic                 unacked;

    logic                 entry_active_reg;
    logic                 entry_latched_reg;
    logic                 summary_valid_reg;
    logic [1:0]           led_mode_reg;
    logic                 unacked_present_reg;
    logic [COUNT_W-1:0]   active_count_reg;

    assign rd_addr     = AW'(in_entry_index);
    assign rd_in_range = (32'(in_entry_index) < TABLE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latching_mode_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            latching_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_row_reg       <= mem[rd_addr];
            rd_valid_reg     <= rd_in_range && row_valid_reg[rd_addr];
            cap_action_reg   <= in_action;
            cap_addr_reg     <= rd_addr;
            cap_in_range_reg <= rd_in_range;
            cap_status_reg   <= in_source_status;
            cap_mask_reg     <= in_entry_mask;
            cap_limit_reg    <= in_wait_limit;
            cap_led_reg      <= in_led_bits;
            cap_storable_reg <= in_storable;
            cap_ack_reg      <= in_acknowledge;
            cap_last_reg     <= in_last_of_scan;
        end
        if (row_we)
        begin
            mem[cap_addr_reg] <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (row_we)
        begin
            row_valid_reg[cap_addr_reg] <= 1'b1;
        end
    end

    // An entry that was never written reads as the all-zero reset row.
    always_comb
    begin
        cur_row  = rd_valid_reg ? rd_row_reg : '0;
        row_next = cur_row;
        disabled = (cur_row.mask == '0) || (cur_row.limit == '0);
        hit      = |(cap_status_reg & cur_row.mask);
        cnt_inc  = {1'b0, cur_row.wait_cnt} + {{BYTE_W{1'b0}}, 1'b1};
        eval_ok  = (cap_action_reg == ACTION_EVAL) && cap_in_range_reg;
        row_we   = cmd.commit && cap_in_range_reg;

        if (cap_action_reg == ACTION_LOAD)
        begin
            row_next.mask     = cap_mask_reg;
            row_next.limit    = cap_limit_reg;
            row_next.led      = cap_led_reg;
            row_next.storable = cap_storable_reg;
        end
        else if (disabled)
        begin
            row_next.active  = 1'b0;
            row_next.latched = 1'b0;
        end
        else
        begin
            if (hit)
            begin
                if (cnt_inc >= {1'b0, cur_row.limit})
                begin
                    row_next.wait_cnt = cur_row.limit;
                    row_next.active   = 1'b1;
                end
                else
                begin
                    row_next.wait_cnt = cnt_inc[BYTE_W-1:0];
                end
            end
            else
            begin
                row_next.wait_cnt = '0;
                row_next.active   = 1'b0;
            end
            if (cur_row.storable)
            begin
                if (!latching_mode_reg)
                begin
                    row_next.latched = row_next.active;
                end
                else if (cap_ack_reg)
                begin
                    row_next.latched = 1'b0;
                end
                else
                begin
                    row_next.latched = cur_row.latched | row_next.active;
                end
            end
        end
    end

    always_comb
    begin
        act       = eval_ok && row_next.active;
        lat       = eval_ok && row_next.latched;
        led_acc   = act ? (scan_led_reg | cur_row.led) : scan_led_reg;
        latch_acc = scan_latch_reg | lat;
        count_acc = (act && (scan_count_reg != COUNT_MAX))
                    ? scan_count_reg + COUNT_W'(1) : scan_count_reg;
        summary   = (cap_action_reg == ACTION_EVAL) && cap_last_reg;

        held_mode_next    = held_mode_reg;
        held_unacked_next = held_unacked_reg;

        if (latching_mode_reg && cap_ack_reg)
        begin
            mode    = held_mode_reg;
            unacked = held_unacked_reg;
        end
        else
        begin
            if (led_acc == LED_NONE)
            begin
                mode = MODE_OFF;
            end
            else if (led_acc == LED_FAULT_ONLY)
            begin
                mode = MODE_SINGLE;
            end
            else
            begin
                mode = MODE_STEADY;
            end
            unacked = latching_mode_reg && latch_acc;
            if (unacked && (led_acc == LED_NONE))
            begin
                mode = MODE_DOUBLE;
            end
            if (summary)
            begin
                held_mode_next    = mode;
                held_unacked_next = unacked;
            end
        end

        if (summary)
        begin
            scan_led_next   = '0;
            scan_latch_next = 1'b0;
            scan_count_next = '0;
        end
        else
        begin
            scan_led_next   = led_acc;
            scan_latch_next = latch_acc;
            scan_count_next = count_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_led_reg     <= '0;
            scan_latch_reg   <= 1'b0;
            scan_count_reg   <= '0;
            held_mode_reg    <= MODE_OFF;
            held_unacked_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            scan_led_reg     <= scan_led_next;
            scan_latch_reg   <= scan_latch_next;
            scan_count_reg   <= scan_count_next;
            held_mode_reg    <= held_mode_next;
            held_unacked_reg <= held_unacked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            entry_active_reg    <= act;
            entry_latched_reg   <= lat;
            summary_valid_reg   <= summary;
            led_mode_reg        <= summary ? mode : MODE_OFF;
            unacked_present_reg <= summary && unacked;
            active_count_reg    <= summary ? count_acc : '0;
        end
    end

    assign res_entry_active    = entry_active_reg;
    assign res_entry_latched   = entry_latched_reg;
    assign res_summary_valid   = summary_valid_reg;
    assign res_led_mode        = led_mode_reg;
    assign res_alarm_relay     = (led_mode_reg == MODE_STEADY);
    assign res_any_alarm       = (led_mode_reg == MODE_SINGLE) || (led_mode_reg == MODE_STEADY);
    assign res_unacked_present = unacked_present_reg;
    assign res_active_count    = active_count_reg;
endmodule

// ===== rtl/alarm_table_qualifier_latch.sv =====
// Top level of the alarm table qualifier and latch.
//
// The item channel takes load beats, which write an entry's mask, wait limit,
// LED bits and storable flag, and evaluate beats, which qualify an entry
// against a source status byte. Every accepted beat yields exactly one beat
// on the result channel; the last evaluate beat of a scan also carries the
// LED, relay, unacknowledged and active-count summary.
// The single configuration register selects latching or transparent mode.
// An item is read, then qualified: on acceptance its table row is read from
// the single-port entry memory; in the execute state the item is qualified,
// its row is written back and the result register is loaded once that register
// is free. A new item is accepted only once the last has left the execute state.
// While the result register is full and not taken, one further item is
// accepted and then waits with its row read until the result is taken.
// Reset empties the table, so every entry reads as disabled with clear
// counters and flags, clears the scan state and selects latching mode.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps

module alarm_table_qualifier_latch #(
    parameter int TABLE_DEPTH = atql_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    atql_in_if.sink    item,
    atql_out_if.source result
);
    import atql_pkg::*;

    cmd_t cmd;

    atql_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    atql_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .cmd                 (cmd),
        .in_action           (item.action),
        .in_entry_index      (item.entry_index),
        .in_source_status    (item.source_status),
        .in_entry_mask       (item.entry_mask),
        .in_wait_limit       (item.wait_limit),
        .in_led_bits         (item.led_bits),
        .in_storable         (item.storable),
        .in_acknowledge      (item.acknowledge),
        .in_last_of_scan     (item.last_of_scan),
        .res_entry_active    (result.entry_active),
        .res_entry_latched   (result.entry_latched),
        .res_summary_valid   (result.summary_valid),
        .res_led_mode        (result.led_mode),
        .res_alarm_relay     (result.alarm_relay),
        .res_any_alarm       (result.any_alarm),
        .res_unacked_present (result.unacked_present),
        .res_active_count    (result.active_count)
    );
endmodule
